// ----- hdl/gss_pkg.sv -----
// Shared constants, command codes and fixed-point helpers for the actuator solver.
// No dependencies; imported by gss_div and the solver.
`default_nettype none
package gss_pkg;
  localparam int MAX_ROWS  = 32;
  localparam int FRAC_BITS = 16;
  localparam int SLOTS     = 32;
  localparam int DW        = 32;
  localparam int RW        = $clog2(MAX_ROWS);
  localparam int MW        = $clog2(MAX_ROWS * MAX_ROWS);
  localparam int SW        = $clog2(SLOTS);
  localparam int AROWW     = 5;
  localparam int ACCW      = 2 * DW + 8;
  localparam int NUMW      = DW + 1 + FRAC_BITS;
  localparam int EFF_MAX   = (MAX_ROWS < 32) ? MAX_ROWS : 32;

  typedef enum logic [1:0] {
    CMD_MATRIX = 2'd0,
    CMD_ROW    = 2'd1,
    CMD_ACT    = 2'd2,
    CMD_START  = 2'd3
  } cmd_t;

  localparam logic [3:0] ADDR_ROW_COUNT = 4'h0;
  localparam logic [3:0] ADDR_ACT_COUNT = 4'h4;
  localparam logic [3:0] ADDR_MODE      = 4'h8;
  localparam logic [3:0] ADDR_SWEEPS    = 4'hC;

  localparam logic signed [ACCW-1:0] SAT_HI = {{(ACCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] SAT_LO = {{(ACCW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACCW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[DW-1:0];
    else if (v < SAT_LO) r = SAT_LO[DW-1:0];
    else r = v[DW-1:0];
    return r;
  endfunction

  // Scale a full product down by the fraction width, rounding half up.
  function automatic logic signed [ACCW-1:0] fx_round(input logic signed [2*DW-1:0] p);
    logic signed [ACCW-1:0] e;
    e = ACCW'(p);
    e = e + ACCW'(1 << (FRAC_BITS - 1));
    return e >>> FRAC_BITS;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/gss_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/gss_div.sv -----
// Restoring signed divider, one quotient bit per cycle: (num * 2^FRAC_BITS) / den,
// truncated toward zero. Depends on gss_pkg.
`default_nettype none
module gss_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [gss_pkg::DW:0]     num,
  input  wire logic signed [gss_pkg::DW-1:0]   den,
  output logic                                 done,
  output logic signed [gss_pkg::NUMW:0]        quot
);
  import gss_pkg::*;

  localparam int CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] dvd_r;
  logic [DW-1:0]   rem_r, den_r;
  logic            neg_r, run_r;
  logic [CW-1:0]   cnt_r;
  logic [DW:0]     trial;
  logic            fits;
  logic [DW:0]     num_mag;
  logic [DW-1:0]   den_mag;

  assign num_mag = num[DW] ? (DW+1)'(-num) : num;
  assign den_mag = den[DW-1] ? DW'(-den) : den;
  assign trial   = {rem_r, dvd_r[NUMW-1]};
  assign fits    = trial >= {1'b0, den_r};
  assign quot    = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
        rem_r <= '0;
        den_r <= den_mag;
        neg_r <= num[DW] ^ den[DW-1];
        cnt_r <= CW'(NUMW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        dvd_r <= {dvd_r[NUMW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/actuator_gauss_seidel_solver.sv -----
// Load commands are accepted back to back while the solver is idle.
// A start command runs the solve and then emits one result per row, row_count
// clamped to 1..32; each Gauss-Seidel row update runs a multiply-accumulate pass
// over the actuators, then the serial divider. Results cannot be stalled.
// Synchronous active-low reset clears control and sets configuration to defaults; stores hold no reset.
// Depends on gss_pkg, gss_ram and gss_div.
`default_nettype none
module actuator_gauss_seidel_solver (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_cmd,
  input  wire logic [4:0]                   in_row,
  input  wire logic [4:0]                   in_col,
  input  wire logic signed [31:0]           in_coefficient,
  input  wire logic signed [31:0]           in_free_displacement,
  input  wire logic signed [31:0]           in_initial_force,
  input  wire logic [4:0]                   in_slot,
  input  wire logic [4:0]                   in_problem_row,
  input  wire logic signed [31:0]           in_target,
  output logic                              out_valid,
  output logic [4:0]                        out_result_row,
  output logic signed [31:0]                out_displacement,
  output logic                              out_last,
  output logic                              out_singular
);
  import gss_pkg::*;

  typedef enum logic [3:0] {
    IDLE, F_RD, F_WR, S_ACT, S_ACTW, S_FREE, M_ACT, M_ACTW, M_MUL, M_ACC,
    D_RD, D_WT, D_DIV, O_FREE, O_FREEW, O_RD
  } state_t;
  // OP_MUL / OP_ACC / OP_EMIT are sub-steps of O_RD, held in ostep_r below.
  typedef enum logic [1:0] {OP_NONE, OP_MUL, OP_ACC, OP_EMIT} ostep_t;

  state_t state_r;
  ostep_t ostep_r;

  logic [5:0] row_count_r, act_count_r;
  logic       mode_r;
  logic [7:0] sweep_r;

  logic [5:0]  nrows_r, na_r;
  logic        fmode_r;
  logic [7:0]  sweeps_r, s_r;
  logic [SW-1:0] k_r, m_r;
  logic [RW-1:0] r_r, i_r, j_r;
  logic signed [DW-1:0] t_r, f_r;
  logic signed [2*DW-1:0] prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic singular_r;

  // Memory ports.
  logic              mat_we, frc_we, fre_we, act_we;
  logic [MW-1:0]     mat_waddr, mat_raddr;
  logic [RW-1:0]     frc_waddr, frc_raddr, fre_raddr;
  logic [DW-1:0]     mat_wdata, frc_wdata, mat_rdata, frc_rdata, fre_rdata;
  logic [SW-1:0]     act_raddr;
  logic [AROWW+DW-1:0] act_rdata;

  logic accept;
  logic [AROWW-1:0] act_row;
  logic signed [DW-1:0] act_tgt;
  logic row_ok, k_last, m_last, s_last, i_last, j_last;
  logic signed [DW-1:0] d_sat;
  logic signed [DW:0] err;
  logic div_start, div_done;
  logic signed [NUMW:0] quot;
  logic signed [DW-1:0] upd;
  logic [5:0] eff_rows, eff_acts;

  gss_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS * MAX_ROWS)) u_mat (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata));
  gss_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_free (
    .clk, .we(fre_we), .waddr(RW'(in_row)), .wdata(in_free_displacement),
    .raddr(fre_raddr), .rdata(fre_rdata));
  gss_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_force (
    .clk, .we(frc_we), .waddr(frc_waddr), .wdata(frc_wdata),
    .raddr(frc_raddr), .rdata(frc_rdata));
  gss_ram #(.WIDTH(AROWW + DW), .DEPTH(SLOTS)) u_act (
    .clk, .we(act_we), .waddr(SW'(in_slot)), .wdata({in_problem_row, in_target}),
    .raddr(act_raddr), .rdata(act_rdata));

  gss_div u_div (
    .clk, .rst_n, .start(div_start), .num(err), .den($signed(mat_rdata)),
    .done(div_done), .quot);

  assign pready  = 1'b1;
  assign busy    = (state_r != IDLE);
  assign accept  = start && !busy;
  assign act_row = act_rdata[AROWW+DW-1:DW];
  assign act_tgt = act_rdata[DW-1:0];
  assign row_ok  = int'(act_row) < int'(nrows_r);
  assign k_last  = int'(k_r) == int'(na_r) - 1;
  assign m_last  = int'(m_r) == int'(na_r) - 1;
  assign s_last  = int'(s_r) == int'(sweeps_r) - 1;
  assign i_last  = int'(i_r) == int'(nrows_r) - 1;
  assign j_last  = int'(j_r) == int'(nrows_r) - 1;
  assign d_sat   = sat_dw(acc_r);
  assign err     = (DW+1)'(d_sat) - (DW+1)'(t_r);
  assign div_start = (state_r == D_WT) && (mat_rdata != '0);
  assign upd     = sat_dw(ACCW'(f_r) - ACCW'(quot));

  always_comb begin
    eff_rows = row_count_r;
    if (eff_rows == 6'd0) eff_rows = 6'd1;
    if (int'(eff_rows) > EFF_MAX) eff_rows = 6'(EFF_MAX);
    eff_acts = act_count_r;
    if (eff_acts == 6'd0) eff_acts = 6'd1;
    if (int'(eff_acts) > SLOTS) eff_acts = 6'(SLOTS);
  end

  // Configuration read-back.
  always_comb begin
    unique case (paddr)
      ADDR_ROW_COUNT: prdata = {26'd0, row_count_r};
      ADDR_ACT_COUNT: prdata = {26'd0, act_count_r};
      ADDR_MODE:      prdata = {31'd0, mode_r};
      ADDR_SWEEPS:    prdata = {24'd0, sweep_r};
      default:        prdata = '0;
    endcase
  end

  // Memory write ports: loads while idle, force updates during the solve.
  always_comb begin
    mat_we    = accept && (in_cmd == CMD_MATRIX) && (int'(in_row) < MAX_ROWS)
                && (int'(in_col) < MAX_ROWS);
    mat_waddr = MW'(int'(in_row) * MAX_ROWS + int'(in_col));
    mat_wdata = in_coefficient;
    fre_we    = accept && (in_cmd == CMD_ROW) && (int'(in_row) < MAX_ROWS);
    act_we    = accept && (in_cmd == CMD_ACT);
    frc_we    = fre_we;
    frc_waddr = RW'(in_row);
    frc_wdata = in_initial_force;
    if (state_r == F_WR) begin
      frc_we    = row_ok;
      frc_waddr = RW'(act_row);
      frc_wdata = fmode_r ? act_tgt : '0;
    end else if (state_r == D_DIV) begin
      frc_we    = div_done;
      frc_waddr = r_r;
      frc_wdata = upd;
    end
  end

  // Memory read addresses follow the sequencer state.
  always_comb begin
    act_raddr = k_r;
    fre_raddr = i_r;
    mat_raddr = MW'(int'(i_r) * MAX_ROWS + int'(j_r));
    frc_raddr = j_r;
    unique case (state_r)
      M_ACT:  act_raddr = m_r;
      S_ACTW: fre_raddr = RW'(act_row);
      M_ACTW: begin
        mat_raddr = MW'(int'(r_r) * MAX_ROWS + int'(act_row));
        frc_raddr = RW'(act_row);
      end
      D_RD: begin
        mat_raddr = MW'(int'(r_r) * MAX_ROWS + int'(r_r));
        frc_raddr = r_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      ostep_r     <= OP_NONE;
      row_count_r <= 6'd1;
      act_count_r <= 6'd1;
      mode_r      <= 1'b1;
      sweep_r     <= 8'd10;
      singular_r  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr)
          ADDR_ROW_COUNT: row_count_r <= pwdata[5:0];
          ADDR_ACT_COUNT: act_count_r <= pwdata[5:0];
          ADDR_MODE:      mode_r      <= pwdata[0];
          ADDR_SWEEPS:    sweep_r     <= pwdata[7:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        IDLE: begin
          if (accept && in_cmd == CMD_START) begin
            nrows_r    <= eff_rows;
            na_r       <= eff_acts;
            fmode_r    <= mode_r;
            sweeps_r   <= sweep_r;
            singular_r <= 1'b0;
            k_r        <= '0;
            state_r    <= F_RD;
          end
        end
        F_RD: state_r <= F_WR;
        F_WR: begin
          if (!k_last) begin
            k_r     <= k_r + 1'b1;
            state_r <= F_RD;
          end else if (fmode_r || sweeps_r == 8'd0) begin
            i_r     <= '0;
            state_r <= O_FREE;
          end else begin
            k_r     <= '0;
            s_r     <= '0;
            state_r <= S_ACT;
          end
        end
        S_ACT: state_r <= S_ACTW;
        S_ACTW: begin
          r_r <= RW'(act_row);
          t_r <= act_tgt;
          if (row_ok) begin
            state_r <= S_FREE;
          end else if (!k_last) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_ACT;
          end else if (!s_last) begin
            k_r     <= '0;
            s_r     <= s_r + 1'b1;
            state_r <= S_ACT;
          end else begin
            i_r     <= '0;
            state_r <= O_FREE;
          end
        end
        S_FREE: begin
          acc_r   <= ACCW'($signed(fre_rdata));
          m_r     <= '0;
          state_r <= M_ACT;
        end
        M_ACT: state_r <= M_ACTW;
        M_ACTW: begin
          if (row_ok) begin
            state_r <= M_MUL;
          end else if (m_last) begin
            state_r <= D_RD;
          end else begin
            m_r     <= m_r + 1'b1;
            state_r <= M_ACT;
          end
        end
        M_MUL: begin
          prod_r  <= $signed(mat_rdata) * $signed(frc_rdata);
          state_r <= M_ACC;
        end
        M_ACC: begin
          acc_r <= acc_r + fx_round(prod_r);
          if (m_last) begin
            state_r <= D_RD;
          end else begin
            m_r     <= m_r + 1'b1;
            state_r <= M_ACT;
          end
        end
        D_RD: state_r <= D_WT;
        D_WT: begin
          f_r <= frc_rdata;
          if (mat_rdata != '0) begin
            state_r <= D_DIV;
          end else begin
            // A zero diagonal leaves the force untouched and flags the run.
            singular_r <= 1'b1;
            if (!k_last) begin
              k_r     <= k_r + 1'b1;
              state_r <= S_ACT;
            end else if (!s_last) begin
              k_r     <= '0;
              s_r     <= s_r + 1'b1;
              state_r <= S_ACT;
            end else begin
              i_r     <= '0;
              state_r <= O_FREE;
            end
          end
        end
        D_DIV: begin
          if (div_done) begin
            if (!k_last) begin
              k_r     <= k_r + 1'b1;
              state_r <= S_ACT;
            end else if (!s_last) begin
              k_r     <= '0;
              s_r     <= s_r + 1'b1;
              state_r <= S_ACT;
            end else begin
              i_r     <= '0;
              state_r <= O_FREE;
            end
          end
        end
        O_FREE: state_r <= O_FREEW;
        O_FREEW: begin
          acc_r   <= ACCW'($signed(fre_rdata));
          j_r     <= '0;
          ostep_r <= OP_NONE;
          state_r <= O_RD;
        end
        O_RD: begin
          // Output pass: read, multiply, accumulate per column, then emit.
          unique case (ostep_r)
            OP_NONE: ostep_r <= OP_MUL;
            OP_MUL: begin
              prod_r  <= $signed(mat_rdata) * $signed(frc_rdata);
              ostep_r <= OP_ACC;
            end
            OP_ACC: begin
              acc_r <= acc_r + fx_round(prod_r);
              if (j_last) begin
                ostep_r <= OP_EMIT;
              end else begin
                j_r     <= j_r + 1'b1;
                ostep_r <= OP_NONE;
              end
            end
            OP_EMIT: begin
              out_valid        <= 1'b1;
              out_result_row   <= 5'(i_r);
              out_displacement <= d_sat;
              out_last         <= i_last;
              out_singular     <= singular_r;
              ostep_r          <= OP_NONE;
              if (i_last) begin
                state_r <= IDLE;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= O_FREE;
              end
            end
            default: ostep_r <= OP_NONE;
          endcase
        end
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
